@@ hw/rtl/bbe_pkg.sv @@
// ----------------------------------------------------------------------------
// bbe_pkg: shared types and constants of the 3x3 box blur
// Pixel word, neighbourhood sums, tap masks, command and register codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbe_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } reg_index_t;

    // input word commands
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    // channel sums of up to nine 8-bit samples
    localparam int SUM_W   = 12;
    localparam int COUNT_W = 4;
    // reciprocal scale for the rounded mean
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 17;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic [SUM_W-1:0]   red;
        logic [SUM_W-1:0]   green;
        logic [SUM_W-1:0]   blue;
        logic [COUNT_W-1:0] count;
    } sum_t;

    // index 0 is the top row / left column, 2 the bottom row / right column
    typedef struct packed {
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } mask_t;

    // ceil(2^17 / (2n)) for n = 1..9, exact over the whole sum range
    function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        begin
            case (n)
                4'd1:    r = 17'd65536;
                4'd2:    r = 17'd32768;
                4'd3:    r = 17'd21846;
                4'd4:    r = 17'd16384;
                4'd5:    r = 17'd13108;
                4'd6:    r = 17'd10923;
                4'd7:    r = 17'd9363;
                4'd8:    r = 17'd8192;
                4'd9:    r = 17'd7282;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bbe_line_store.sv @@
// ----------------------------------------------------------------------------
// bbe_line_store: one row of pixels
// Single-port-write, registered-read memory holding a previous row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbe_line_store #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output bbe_pkg::pix_t        rd_data,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire bbe_pkg::pix_t   wr_data
);
    import bbe_pkg::*;

    pix_t mem [DEPTH];
    pix_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bbe_window_sum.sv @@
// ----------------------------------------------------------------------------
// bbe_window_sum: nine-tap window and masked neighbourhood sums
// Shifts in one column per pixel and sums the in-frame taps per channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbe_window_sum (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift_en,
    input  wire bbe_pkg::pix_t   col_top,
    input  wire bbe_pkg::pix_t   col_mid,
    input  wire bbe_pkg::pix_t   col_bot,
    input  wire logic            sum_en,
    input  wire bbe_pkg::mask_t  mask,
    output bbe_pkg::sum_t        sums
);
    import bbe_pkg::*;

    pix_t win_reg [9];
    sum_t sums_reg;
    sum_t sums_next;

    // window taps, column-major, oldest column first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= win_reg[i+3];
            end
            win_reg[6] <= col_top;
            win_reg[7] <= col_mid;
            win_reg[8] <= col_bot;
        end
    end

    // masked sums over the nine taps
    always_comb
    begin
        sums_next = '0;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (mask.col_ok[c] && mask.row_ok[r])
                begin
                    sums_next.red   = sums_next.red   + SUM_W'(win_reg[c*3+r].red);
                    sums_next.green = sums_next.green + SUM_W'(win_reg[c*3+r].green);
                    sums_next.blue  = sums_next.blue  + SUM_W'(win_reg[c*3+r].blue);
                    sums_next.count = sums_next.count + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_en)
        begin
            sums_reg <= sums_next;
        end
    end

    assign sums = sums_reg;

endmodule

`default_nettype wire

@@ hw/rtl/bbe_mean.sv @@
// ----------------------------------------------------------------------------
// bbe_mean: rounded channel means
// Computes (2*sum+n) div (2n) per channel by reciprocal multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbe_mean (
    input  wire bbe_pkg::sum_t  sums,
    output bbe_pkg::pix_t       mean
);
    import bbe_pkg::*;

    localparam int NUM_W  = SUM_W + 1;
    localparam int PROD_W = NUM_W + RECIP_W;

    logic [RECIP_W-1:0] scale;

    function automatic logic [7:0] chan_mean(input logic [SUM_W-1:0] s,
                                             input logic [COUNT_W-1:0] n,
                                             input logic [RECIP_W-1:0] k);
        logic [NUM_W-1:0]  num;
        logic [PROD_W-1:0] prod;
        begin
            num  = {s, 1'b0} + NUM_W'(n);
            prod = PROD_W'(num) * PROD_W'(k);
            return prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    endfunction

    // shared reciprocal of the divisor
    assign scale = recip(sums.count);

    // one multiply per channel
    always_comb
    begin
        mean.red   = chan_mean(sums.red,   sums.count, scale);
        mean.green = chan_mean(sums.green, sums.count, scale);
        mean.blue  = chan_mean(sums.blue,  sums.count, scale);
    end

endmodule

`default_nettype wire

@@ hw/rtl/box_blur_3x3_edge_aware_core.sv @@
// Steps: a taken word reads the line stores in idle and is written back and shifted
// into the window in read; a word with a result is then summed in sum and multiplied
// in multiply, which loads the output word and waits while the old one is held. in_ready
// is high only in idle, so a word is done before the next; drains before frame end drop.
// Reset: asynchronous, active low; counters and window clear, registers take
// 640 x 480, line stores keep their contents and need no clearing pass.
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core: edge-aware 3x3 box blur top level
// Counters, sequencer, line stores, window and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_edge_aware_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            cmd,
    input  wire logic [7:0]                      in_red,
    input  wire logic [7:0]                      in_green,
    input  wire logic [7:0]                      in_blue,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [7:0]                           out_red,
    output logic [7:0]                           out_green,
    output logic [7:0]                           out_blue,
    output logic                                 end_of_row,
    output logic                                 end_of_frame
);
    import bbe_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = 17;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_MUL
    } state_t;

    state_t        state_reg;
    state_t        state_next;

    logic [10:0]   width_reg;
    logic [15:0]   height_reg;
    logic [RW-1:0] in_row_reg;
    logic [CW-1:0] in_col_reg;
    logic [15:0]   out_row_reg;
    logic [CW-1:0] out_col_reg;

    pix_t          pix_reg;
    logic [CW-1:0] col_reg;
    logic          emit_reg;
    logic          eor_reg;
    logic          eof_reg;

    logic          out_valid_reg;
    pix_t          out_pix_reg;
    logic          out_eor_reg;
    logic          out_eof_reg;

    logic [CW:0]   eff_w;
    logic [15:0]   eff_h;
    logic          in_fire;
    logic          frame_done;
    logic          take;
    logic          in_wrap;
    logic          emit_next;
    logic          out_free;
    mask_t         mask;
    logic          eor;
    logic          eof;
    pix_t          older_q;
    pix_t          newer_q;
    sum_t          sums;
    pix_t          mean;
    logic          shift_en;
    logic          sum_en;

    // effective frame size
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = (CW+1)'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = (CW+1)'(MAX_WIDTH);
        end
        else
        begin
            eff_w = (CW+1)'(width_reg);
        end
        eff_h = (height_reg == '0) ? 16'd1 : height_reg;
    end

    // input side decisions
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign frame_done = (in_row_reg >= RW'(eff_h));
    assign take       = in_fire && (frame_done || (cmd == CMD_PIXEL));
    assign in_wrap    = ((CW+1)'(in_col_reg) + (CW+1)'(1)) >= eff_w;
    assign emit_next  = (in_row_reg >= RW'(2)) ||
                        ((in_row_reg == RW'(1)) && (in_col_reg != '0));

    // output side masks and marks
    always_comb
    begin
        mask.row_ok[0] = (out_row_reg != '0);
        mask.row_ok[1] = 1'b1;
        mask.row_ok[2] = (RW'(out_row_reg) + RW'(1)) < RW'(eff_h);
        mask.col_ok[0] = (out_col_reg != '0);
        mask.col_ok[1] = 1'b1;
        mask.col_ok[2] = ((CW+1)'(out_col_reg) + (CW+1)'(1)) < eff_w;
    end

    assign eor      = !mask.col_ok[2];
    assign eof      = eor && !mask.row_ok[2];
    assign out_free = !out_valid_reg || out_ready;
    assign shift_en = (state_reg == ST_READ);
    assign sum_en   = (state_reg == ST_SUM);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = emit_reg ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, counters, registers and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= 11'd640;
            height_reg    <= 16'd480;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // accepted word: step the input counters
            if (take)
            begin
                emit_reg <= emit_next;
                if (in_wrap)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end

            // neighbourhood summed: step the output counters, at the frame end clear all counters
            if (state_reg == ST_SUM)
            begin
                if (eof)
                begin
                    in_row_reg  <= '0;
                    in_col_reg  <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end
                else if (eor)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 16'd1;
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end

            // output word register
            if ((state_reg == ST_MUL) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // register writes restart the frame
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg   <= cfg_data[10:0];
                        in_row_reg  <= '0;
                        in_col_reg  <= '0;
                        out_row_reg <= '0;
                        out_col_reg <= '0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg  <= cfg_data[15:0];
                        in_row_reg  <= '0;
                        in_col_reg  <= '0;
                        out_row_reg <= '0;
                        out_col_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg <= frame_done ? pix_t'('0) : pix_t'({in_red, in_green, in_blue});
            col_reg <= in_col_reg;
        end
        if (state_reg == ST_SUM)
        begin
            eor_reg <= eor;
            eof_reg <= eof;
        end
        if ((state_reg == ST_MUL) && out_free)
        begin
            out_pix_reg <= mean;
            out_eor_reg <= eor_reg;
            out_eof_reg <= eof_reg;
        end
    end

    // row before last
    bbe_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .rd_data (older_q),
        .wr_en   (shift_en),
        .wr_addr (col_reg),
        .wr_data (newer_q)
    );

    // last row
    bbe_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_newer (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .rd_data (newer_q),
        .wr_en   (shift_en),
        .wr_addr (col_reg),
        .wr_data (pix_reg)
    );

    // window and sums
    bbe_window_sum u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .col_top  (older_q),
        .col_mid  (newer_q),
        .col_bot  (pix_reg),
        .sum_en   (sum_en),
        .mask     (mask),
        .sums     (sums)
    );

    // rounded means
    bbe_mean u_mean (
        .sums (sums),
        .mean (mean)
    );

    assign out_valid    = out_valid_reg;
    assign out_red      = out_pix_reg.red;
    assign out_green    = out_pix_reg.green;
    assign out_blue     = out_pix_reg.blue;
    assign end_of_row   = out_eor_reg;
    assign end_of_frame = out_eof_reg;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the edge-aware 3x3 box blur
// Streams frames of rgb words through the core, predicts every blurred word
// from its own line stores and window, and compares results field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import bbe_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 800;
    localparam int REPORT_LIMIT  = 10;

    // indexes past the register list, writes to them are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eor;
        logic       eof;
    } blur_word_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  cmd       = CMD_PIXEL;
    logic [7:0]            in_red    = '0;
    logic [7:0]            in_green  = '0;
    logic [7:0]            in_blue   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic                  end_of_row;
    logic                  end_of_frame;

    box_blur_3x3_edge_aware_core #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame)
    );

    // scoreboard: mirrors the line stores and window, queues blurred words
    class blur_tracker;
        logic [10:0]  width_reg;
        logic [15:0]  height_reg;
        pix_t         older_ln [MAX_W];
        pix_t         newer_ln [MAX_W];
        pix_t         win [9];
        int unsigned  in_row, in_col, out_row, out_col;
        blur_word_t   pending_means [$];
        int           mismatches;

        function new();
            int i;
            width_reg  = 11'd640;
            height_reg = 16'd480;
            for (i = 0; i < MAX_W; i++)
            begin
                older_ln[i] = '0;
                newer_ln[i] = '0;
            end
            for (i = 0; i < 9; i++)
                win[i] = '0;
            clear_counters();
            mismatches = 0;
        endfunction

        function void clear_counters();
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH)
            begin
                width_reg = val[10:0];
                clear_counters();
            end
            else if (idx == REG_IMAGE_HEIGHT)
            begin
                height_reg = val;
                clear_counters();
            end
        endfunction

        // one accepted input word, may queue one blurred word
        function void accept_word(cmd_t c, pix_t p);
            int unsigned w, h, ir, ic, col, n, i, k;
            int unsigned sum_r, sum_g, sum_b;
            pix_t        v;
            bit          emit, eor, eof;
            bit          row_ok [3];
            bit          col_ok [3];
            blur_word_t  res;
            w  = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
            h  = (height_reg == 0) ? 1 : height_reg;
            ir = in_row;
            ic = in_col;

            // past the last row every word is a drain carrying black
            if (in_row >= h)
                v = '0;
            else if (c == CMD_DRAIN)
                return;
            else
                v = p;

            // shift the window and rotate the line stores
            col = ic % MAX_W;
            for (i = 0; i < 6; i++)
                win[i] = win[i + 3];
            win[6] = older_ln[col];
            win[7] = newer_ln[col];
            win[8] = v;
            older_ln[col] = newer_ln[col];
            newer_ln[col] = v;

            emit = (ir >= 2) || (ir == 1 && ic >= 1);
            if (ic + 1 >= w)
            begin
                in_col = 0;
                in_row = ir + 1;
            end
            else
                in_col = ic + 1;
            if (!emit)
                return;

            // mean over the taps that fall inside the frame
            eor = (out_col + 1 >= w);
            eof = eor && (out_row + 1 >= h);
            row_ok[0] = (out_row >= 1);
            row_ok[1] = 1'b1;
            row_ok[2] = (out_row + 1 < h);
            col_ok[0] = (out_col >= 1);
            col_ok[1] = 1'b1;
            col_ok[2] = (out_col + 1 < w);
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            n     = 0;
            for (k = 0; k < 3; k++)
                for (i = 0; i < 3; i++)
                    if (col_ok[k] && row_ok[i])
                    begin
                        sum_r += win[k * 3 + i].red;
                        sum_g += win[k * 3 + i].green;
                        sum_b += win[k * 3 + i].blue;
                        n++;
                    end
            res.red   = 8'((2 * sum_r + n) / (2 * n));
            res.green = 8'((2 * sum_g + n) / (2 * n));
            res.blue  = 8'((2 * sum_b + n) / (2 * n));
            res.eor   = eor;
            res.eof   = eof;
            pending_means.push_back(res);

            if (eof)
                clear_counters();
            else if (eor)
            begin
                out_col = 0;
                out_row++;
            end
            else
                out_col++;
        endfunction

        function int pending();
            return pending_means.size();
        endfunction

        function void check_output(blur_word_t got);
            blur_word_t want;
            if (pending_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: r=%0d g=%0d b=%0d eor=%0b eof=%0b",
                             got.red, got.green, got.blue, got.eor, got.eof);
                return;
            end
            want = pending_means.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.eor !== want.eor || got.eof !== want.eof)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"mismatch: expected r=%0d g=%0d b=%0d eor=%0b eof=%0b,",
                              " got r=%0d g=%0d b=%0d eor=%0b eof=%0b"},
                             want.red, want.green, want.blue, want.eor, want.eof,
                             got.red, got.green, got.blue, got.eor, got.eof);
            end
        endfunction
    endclass

    blur_tracker tracker;
    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    int          phase_left  = 0;
    rx_mode_t    stall_mode  = RX_ALWAYS;
    blur_word_t  seen;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check accepted words, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            seen.red   = out_red;
            seen.green = out_green;
            seen.blue  = out_blue;
            seen.eor   = end_of_row;
            seen.eof   = end_of_frame;
            tracker.check_output(seen);
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                phase_left = $urandom_range(16, 96);
            end
            else
                phase_left--;
            case (stall_mode)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= ((phase_left % 16) < 10);
            endcase
        end
    end

    // random channel values, biased towards the extremes
    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pix_t rand_pix();
        pix_t p;
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        return p;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.write_register(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // offer one word, hold it until taken, then maybe leave a gap
    task automatic send_word(input cmd_t c, input pix_t p);
        cmd      <= c;
        in_red   <= p.red;
        in_green <= p.green;
        in_blue  <= p.blue;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        tracker.accept_word(c, p);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                     : $urandom_range(0, 12);
        end
        else
            burst_left--;
    endtask

    task automatic send_pixels(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
            send_word(CMD_PIXEL, rand_pix());
    endtask

    // frame tail: drain words, now and then a pixel that acts as one
    task automatic drain_frame(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
            if ($urandom_range(0, 5) == 0)
                send_word(CMD_PIXEL, rand_pix());
            else
                send_word(CMD_DRAIN, rand_pix());
    endtask

    // stop offering until every expected word is out and the core is quiet
    task automatic wait_flushed();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int unsigned items, frame_no, fw, fh, raw_w, raw_h, n_pix, cut, p;
        bit          force_cfg;
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x2 frame with extreme values, early drain and ignored registers
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        send_word(CMD_PIXEL, 24'hFFFFFF);
        send_word(CMD_PIXEL, 24'h000000);
        send_word(CMD_PIXEL, 24'hFF0001);
        send_word(CMD_DRAIN, 24'hFFFFFF);
        wait_flushed();
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h0001);
        send_word(CMD_PIXEL, 24'h00FFFE);
        send_word(CMD_PIXEL, 24'h807F01);
        send_word(CMD_PIXEL, 24'hFFFF00);
        send_word(CMD_DRAIN, 24'h000000);
        send_word(CMD_PIXEL, 24'hFFFFFF);
        send_word(CMD_DRAIN, 24'h5A5A5A);
        send_word(CMD_DRAIN, 24'hA5A5A5);
        // drain with nothing pending
        send_word(CMD_DRAIN, 24'h123456);
        wait_flushed();

        // zero width and height act as a single pixel frame
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        send_word(CMD_PIXEL, 24'hC86432);
        send_word(CMD_DRAIN, 24'h000000);
        send_word(CMD_DRAIN, 24'h000000);
        wait_flushed();

        // all white 2x2 frame, full-scale means
        write_reg(REG_IMAGE_WIDTH, 16'd2);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        repeat (4) send_word(CMD_PIXEL, 24'hFFFFFF);
        repeat (3) send_word(CMD_DRAIN, 24'h000000);
        wait_flushed();

        // oversize width clamps to the full line, one row
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        send_pixels(MAX_W);
        drain_frame(MAX_W + 1);
        wait_flushed();

        // tallest frame, started then abandoned
        write_reg(REG_IMAGE_WIDTH, 16'(MAX_W));
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        send_pixels(30);
        wait_flushed();
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        // long receiver hold so the core backs up, then a full pause
        hold_req = 1'b1;
        send_pixels(12);
        wait_flushed();
        send_pixels(8);

        // random frames, mostly small, some cut short
        items     = 0;
        frame_no  = 0;
        force_cfg = 1'b1;
        fw        = 1;
        fh        = 1;
        while (items < RANDOM_ITEMS)
        begin
            frame_no++;
            if (force_cfg || $urandom_range(0, 3) != 0)
            begin
                wait_flushed();
                if ($urandom_range(0, 15) == 0)
                    raw_w = 0;
                else if ($urandom_range(0, 5) == 0)
                    raw_w = $urandom_range(7, 40);
                else
                    raw_w = $urandom_range(1, 6);
                raw_h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 5);
                write_reg(REG_IMAGE_WIDTH, 16'(raw_w));
                write_reg(REG_IMAGE_HEIGHT, 16'(raw_h));
                fw = (raw_w == 0) ? 1 : raw_w;
                fh = (raw_h == 0) ? 1 : raw_h;
                force_cfg = 1'b0;
            end
            n_pix = fw * fh;
            cut   = n_pix;
            if ($urandom_range(0, 9) == 0)
            begin
                cut       = $urandom_range(1, n_pix);
                force_cfg = 1'b1;
            end
            for (p = 0; p < cut; p++)
            begin
                // stray drain inside the frame is dropped
                if ($urandom_range(0, 9) == 0)
                    send_word(CMD_DRAIN, rand_pix());
                send_word(CMD_PIXEL, rand_pix());
                items++;
            end
            if (!force_cfg)
            begin
                drain_frame(fw + 1);
                items += fw + 1;
                if ($urandom_range(0, 4) == 0)
                    send_word(CMD_DRAIN, rand_pix());
            end
        end

        wait_flushed();
        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
